[hw/rtl/rsrs_pkg.sv]
// Package for the RAID stripe request splitter.
// Holds widths, register and layout codes, the back-end state type and shared structs.
// No dependencies.
package rsrs_pkg;

   localparam int MaxPiecesDef  = 64;
   localparam int MaxDevicesDef = 32;

   localparam int AddrW    = 48;
   localparam int LenW     = 32;
   localparam int UnitW    = 17;
   localparam int DevCntW  = 6;
   localparam int ParCntW  = 4;
   localparam int ModeW    = 2;
   localparam int NW       = 7;
   localparam int DivW     = 49;
   localparam int DivCntW  = 6;
   localparam int DevW     = 5;
   localparam int ReqDataW = 80;
   localparam int RspDataW = 120;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   localparam logic [1:0] RegUnitSize     = 2'd0;
   localparam logic [1:0] RegDataDevices  = 2'd1;
   localparam logic [1:0] RegParityDevices = 2'd2;
   localparam logic [1:0] RegLayoutMode   = 2'd3;

   localparam logic [ModeW-1:0] LayoutParity = 2'd1;
   localparam logic [ModeW-1:0] LayoutData   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_FST,
      ST_DIV_SPAN,
      ST_DIV_ROW,
      ST_DIV_RES,
      ST_MUL,
      ST_EMIT,
      ST_ERROR
   } back_state_type;

   typedef struct packed {
      logic [UnitW-1:0]   unit_size;
      logic [DevCntW-1:0] data_devices;
      logic [ParCntW-1:0] parity_devices;
      logic [ModeW-1:0]   layout_mode;
   } cfg_type;

   typedef struct packed {
      logic [AddrW-1:0] start;
      logic [LenW-1:0]  length;
      logic             err;
   } job_type;

   typedef struct packed {
      logic             start;
      logic [DivW-1:0]  dividend;
      logic [UnitW-1:0] divisor;
   } div_req_type;

endpackage

[hw/rtl/raid_stripe_request_splitter_unit.sv]
// Top level of the RAID stripe request splitter: configuration registers and the two halves.
// Depends on rsrs_pkg and instantiates rsrs_front and rsrs_back.
// A request passes through four divisions (unit, span, row and residue) and a shift-add
// multiply before its first piece; error results skip them, and span errors leave after
// the span division. The front end queues two requests while the back end handles one.
// Reset empties the request queue and the output register and restores the default layout.
module raid_stripe_request_splitter_unit #(
   parameter int MAX_PIECES  = rsrs_pkg::MaxPiecesDef,
   parameter int MAX_DEVICES = rsrs_pkg::MaxDevicesDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: req_start[47:0], req_length[79:48].
   input  logic [rsrs_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: device_index[4:0], device_address[52:5], piece_length[69:53],
   // row_index[117:70], zero pad[119:118].
   output logic [rsrs_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   // Fields from bit 0: error.
   output logic                          rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rsrs_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [rsrs_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [rsrs_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);

   rsrs_pkg::cfg_type cfg_ff;
   logic              csr_wr;
   logic              pop;
   logic              job_valid;
   rsrs_pkg::job_type job;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_size      <= rsrs_pkg::UnitW'(64);
         cfg_ff.data_devices   <= rsrs_pkg::DevCntW'(4);
         cfg_ff.parity_devices <= rsrs_pkg::ParCntW'(1);
         cfg_ff.layout_mode    <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            rsrs_pkg::RegUnitSize:
               cfg_ff.unit_size <= csr_pwdata[rsrs_pkg::UnitW-1:0];
            rsrs_pkg::RegDataDevices:
               cfg_ff.data_devices <= csr_pwdata[rsrs_pkg::DevCntW-1:0];
            rsrs_pkg::RegParityDevices:
               cfg_ff.parity_devices <= csr_pwdata[rsrs_pkg::ParCntW-1:0];
            rsrs_pkg::RegLayoutMode:
               cfg_ff.layout_mode <= csr_pwdata[rsrs_pkg::ModeW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         rsrs_pkg::RegUnitSize:      csr_prdata = rsrs_pkg::CsrDataW'(cfg_ff.unit_size);
         rsrs_pkg::RegDataDevices:   csr_prdata = rsrs_pkg::CsrDataW'(cfg_ff.data_devices);
         rsrs_pkg::RegParityDevices: csr_prdata = rsrs_pkg::CsrDataW'(cfg_ff.parity_devices);
         rsrs_pkg::RegLayoutMode:    csr_prdata = rsrs_pkg::CsrDataW'(cfg_ff.layout_mode);
         default:                    csr_prdata = '0;
      endcase
   end

   rsrs_front #(
      .MAX_DEVICES (MAX_DEVICES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .job_valid  (job_valid),
      .job        (job)
   );

   rsrs_back #(
      .MAX_PIECES (MAX_PIECES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job        (job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hw/rtl/rsrs_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rsrs_pkg for widths and the request struct.
module rsrs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  rsrs_pkg::div_req_type      div_req,
   output logic                       done,
   output logic [rsrs_pkg::DivW-1:0]  quot,
   output logic [rsrs_pkg::UnitW-1:0] rem
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [rsrs_pkg::DivCntW-1:0] cnt_ff;
   logic [rsrs_pkg::DivW-1:0]   q_ff;
   logic [rsrs_pkg::UnitW-1:0]  r_ff;
   logic [rsrs_pkg::UnitW-1:0]  d_ff;
   logic [rsrs_pkg::UnitW:0]    trial;
   logic                        qbit;
   logic [rsrs_pkg::UnitW-1:0]  r_in;

   always_comb begin
      trial = {r_ff, q_ff[rsrs_pkg::DivW-1]};
      qbit  = (trial >= {1'b0, d_ff});
      r_in  = qbit ? rsrs_pkg::UnitW'(trial - {1'b0, d_ff}) : trial[rsrs_pkg::UnitW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == rsrs_pkg::DivCntW'(rsrs_pkg::DivW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         q_ff <= div_req.dividend;
         r_ff <= '0;
         d_ff <= div_req.divisor;
      end else if (busy_ff) begin
         q_ff <= {q_ff[rsrs_pkg::DivW-2:0], qbit};
         r_ff <= r_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

[hw/rtl/rsrs_front.sv]
// Front end: accepts requests, flags configuration and length errors, and queues them.
// Depends on rsrs_pkg for the configuration and job structs.
module rsrs_front #(
   parameter int MAX_DEVICES = rsrs_pkg::MaxDevicesDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rsrs_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rsrs_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          pop,
   output logic                          job_valid,
   output rsrs_pkg::job_type             job
);

   rsrs_pkg::job_type mem_ff [2];
   logic              wptr_ff;
   logic              rptr_ff;
   logic [1:0]        cnt_ff;
   rsrs_pkg::job_type entry;
   logic              push;
   logic [rsrs_pkg::NW-1:0] total;

   always_comb begin
      total        = rsrs_pkg::NW'(cfg.data_devices) + rsrs_pkg::NW'(cfg.parity_devices);
      entry.start  = req_tdata[rsrs_pkg::AddrW-1:0];
      entry.length = req_tdata[rsrs_pkg::AddrW +: rsrs_pkg::LenW];
      entry.err    = (cfg.unit_size == '0) || (cfg.data_devices == '0) ||
                     (total > rsrs_pkg::NW'(MAX_DEVICES)) ||
                     (req_tdata[rsrs_pkg::AddrW +: rsrs_pkg::LenW] == '0);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign job_valid  = (cnt_ff != 2'd0);
   assign job        = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= entry;
      end
   end

endmodule

[hw/rtl/rsrs_back.sv]
// Back end: divides out unit, span, row and residue, then emits one piece per cycle
// unless the output stalls, or one error result. Depends on rsrs_pkg and instantiates rsrs_div.
module rsrs_back #(
   parameter int MAX_PIECES = rsrs_pkg::MaxPiecesDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rsrs_pkg::cfg_type             cfg,
   input  logic                          job_valid,
   input  rsrs_pkg::job_type             job,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rsrs_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);

   localparam int KW = $clog2(MAX_PIECES + 1);
   localparam int MulCntW = $clog2(rsrs_pkg::UnitW);

   rsrs_pkg::back_state_type state_ff, state_in;
   rsrs_pkg::div_req_type    div_req;
   logic                     div_done;
   logic [rsrs_pkg::DivW-1:0]  div_quot;
   logic [rsrs_pkg::UnitW-1:0] div_rem;

   logic [rsrs_pkg::LenW-1:0]    len_ff;
   logic [rsrs_pkg::UnitW-1:0]   off_ff;
   logic [rsrs_pkg::UnitW-1:0]   elast_ff;
   logic [KW-1:0]                span_ff;
   logic [KW-1:0]                k_ff;
   logic [rsrs_pkg::DivW-1:0]    row_ff;
   logic [rsrs_pkg::DevCntW-1:0] dev_ff;
   logic [rsrs_pkg::NW-1:0]      r_ff;
   logic [rsrs_pkg::AddrW-1:0]   base_ff;
   logic [rsrs_pkg::AddrW-1:0]   mb_ff;
   logic [rsrs_pkg::UnitW-1:0]   ub_ff;
   logic [MulCntW-1:0]           mcnt_ff;

   logic                         out_valid_ff;
   logic [rsrs_pkg::DevW-1:0]    o_dev_ff;
   logic [rsrs_pkg::AddrW-1:0]   o_addr_ff;
   logic [rsrs_pkg::UnitW-1:0]   o_len_ff;
   logic [rsrs_pkg::AddrW-1:0]   o_row_ff;
   logic                         o_last_ff;
   logic                         o_err_ff;

   logic                         out_free;
   logic                         span_err;
   logic                         first;
   logic                         last;
   logic [rsrs_pkg::UnitW-1:0]   plen;
   logic [rsrs_pkg::AddrW-1:0]   paddr;
   logic [rsrs_pkg::NW-1:0]      n;
   logic [rsrs_pkg::NW:0]        t2;
   logic [rsrs_pkg::NW:0]        s0;
   logic [rsrs_pkg::NW:0]        s;
   logic [rsrs_pkg::NW:0]        e0;
   logic [rsrs_pkg::NW:0]        e;
   logic [rsrs_pkg::NW+1:0]      dmap;
   logic [rsrs_pkg::DevW-1:0]    dev_out;
   logic [rsrs_pkg::NW-1:0]      r_inc;

   rsrs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .done    (div_done),
      .quot    (div_quot),
      .rem     (div_rem)
   );

   assign out_free = !out_valid_ff || rsp_tready;
   assign span_err = (div_quot >= rsrs_pkg::DivW'(MAX_PIECES));

   always_comb begin
      first = (k_ff == '0);
      last  = (k_ff == span_ff);
      priority if (first && last) begin
         plen = len_ff[rsrs_pkg::UnitW-1:0];
      end else if (first) begin
         plen = cfg.unit_size - off_ff;
      end else if (last) begin
         plen = elast_ff + 1'b1;
      end else begin
         plen = cfg.unit_size;
      end
      paddr = base_ff + (first ? rsrs_pkg::AddrW'(off_ff) : '0);

      n  = rsrs_pkg::NW'(cfg.data_devices) + rsrs_pkg::NW'(cfg.parity_devices);
      t2 = (rsrs_pkg::NW+1)'(n) + (rsrs_pkg::NW+1)'(dev_ff) - (rsrs_pkg::NW+1)'(r_ff);
      if (t2 >= (rsrs_pkg::NW+1)'(n)) begin
         t2 = t2 - (rsrs_pkg::NW+1)'(n);
      end
      s0 = (rsrs_pkg::NW+1)'(n) + (rsrs_pkg::NW+1)'(cfg.data_devices) -
           (rsrs_pkg::NW+1)'(r_ff);
      s  = (s0 >= (rsrs_pkg::NW+1)'(n)) ? s0 - (rsrs_pkg::NW+1)'(n) : s0;
      e0 = s + (rsrs_pkg::NW+1)'(cfg.parity_devices) - 1'b1;
      e  = (e0 >= (rsrs_pkg::NW+1)'(n)) ? e0 - (rsrs_pkg::NW+1)'(n) : e0;
      dmap = (rsrs_pkg::NW+2)'(dev_ff);
      if ((rsrs_pkg::NW+1)'(dev_ff) >= s) begin
         dmap = dmap + (rsrs_pkg::NW+2)'(cfg.parity_devices);
      end
      if (e < s) begin
         dmap = dmap + (rsrs_pkg::NW+2)'(e) + 1'b1;
      end
      if (cfg.layout_mode == rsrs_pkg::LayoutData) begin
         dev_out = t2[rsrs_pkg::DevW-1:0];
      end else if (cfg.layout_mode == rsrs_pkg::LayoutParity &&
                   cfg.parity_devices != '0) begin
         dev_out = dmap[rsrs_pkg::DevW-1:0];
      end else begin
         dev_out = dev_ff[rsrs_pkg::DevW-1:0];
      end
      r_inc = (r_ff + 1'b1 == n) ? '0 : r_ff + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsrs_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = job.err ? rsrs_pkg::ST_ERROR : rsrs_pkg::ST_DIV_FST;
            end
         end
         rsrs_pkg::ST_DIV_FST: begin
            if (div_done) begin
               state_in = rsrs_pkg::ST_DIV_SPAN;
            end
         end
         rsrs_pkg::ST_DIV_SPAN: begin
            if (div_done) begin
               state_in = span_err ? rsrs_pkg::ST_ERROR : rsrs_pkg::ST_DIV_ROW;
            end
         end
         rsrs_pkg::ST_DIV_ROW: begin
            if (div_done) begin
               state_in = rsrs_pkg::ST_DIV_RES;
            end
         end
         rsrs_pkg::ST_DIV_RES: begin
            if (div_done) begin
               state_in = rsrs_pkg::ST_MUL;
            end
         end
         rsrs_pkg::ST_MUL: begin
            if (mcnt_ff == MulCntW'(rsrs_pkg::UnitW - 1)) begin
               state_in = rsrs_pkg::ST_EMIT;
            end
         end
         rsrs_pkg::ST_EMIT: begin
            if (out_free && last) begin
               state_in = rsrs_pkg::ST_IDLE;
            end
         end
         rsrs_pkg::ST_ERROR: begin
            if (out_free) begin
               state_in = rsrs_pkg::ST_IDLE;
            end
         end
         default: state_in = rsrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop              = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = rsrs_pkg::DivW'(job.start);
      div_req.divisor  = cfg.unit_size;
      unique case (state_ff)
         rsrs_pkg::ST_IDLE: begin
            pop           = job_valid;
            div_req.start = job_valid && !job.err;
         end
         rsrs_pkg::ST_DIV_FST: begin
            div_req.start    = div_done;
            div_req.dividend = rsrs_pkg::DivW'(div_rem) + rsrs_pkg::DivW'(len_ff) - 1'b1;
         end
         rsrs_pkg::ST_DIV_SPAN: begin
            div_req.start    = div_done && !span_err;
            div_req.dividend = row_ff;
            div_req.divisor  = rsrs_pkg::UnitW'(cfg.data_devices);
         end
         rsrs_pkg::ST_DIV_ROW: begin
            div_req.start    = div_done;
            div_req.dividend = div_quot;
            div_req.divisor  = rsrs_pkg::UnitW'(n);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsrs_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == rsrs_pkg::ST_EMIT || state_ff == rsrs_pkg::ST_ERROR) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rsrs_pkg::ST_IDLE: begin
            len_ff <= job.length;
         end
         rsrs_pkg::ST_DIV_FST: begin
            if (div_done) begin
               row_ff <= div_quot;
               off_ff <= div_rem;
            end
         end
         rsrs_pkg::ST_DIV_SPAN: begin
            if (div_done) begin
               span_ff  <= div_quot[KW-1:0];
               elast_ff <= div_rem;
            end
         end
         rsrs_pkg::ST_DIV_ROW: begin
            if (div_done) begin
               row_ff <= div_quot;
               dev_ff <= div_rem[rsrs_pkg::DevCntW-1:0];
            end
         end
         rsrs_pkg::ST_DIV_RES: begin
            if (div_done) begin
               r_ff    <= div_rem[rsrs_pkg::NW-1:0];
               mb_ff   <= row_ff[rsrs_pkg::AddrW-1:0];
               ub_ff   <= cfg.unit_size;
               base_ff <= '0;
               mcnt_ff <= '0;
               k_ff    <= '0;
            end
         end
         rsrs_pkg::ST_MUL: begin
            if (ub_ff[0]) begin
               base_ff <= base_ff + mb_ff;
            end
            mb_ff   <= {mb_ff[rsrs_pkg::AddrW-2:0], 1'b0};
            ub_ff   <= {1'b0, ub_ff[rsrs_pkg::UnitW-1:1]};
            mcnt_ff <= mcnt_ff + 1'b1;
         end
         rsrs_pkg::ST_EMIT: begin
            if (out_free) begin
               o_dev_ff  <= dev_out;
               o_addr_ff <= paddr;
               o_len_ff  <= plen;
               o_row_ff  <= row_ff[rsrs_pkg::AddrW-1:0];
               o_last_ff <= last;
               o_err_ff  <= 1'b0;
               k_ff      <= k_ff + 1'b1;
               if (dev_ff + 1'b1 == cfg.data_devices) begin
                  dev_ff  <= '0;
                  row_ff  <= row_ff + 1'b1;
                  base_ff <= base_ff + rsrs_pkg::AddrW'(cfg.unit_size);
                  r_ff    <= r_inc;
               end else begin
                  dev_ff <= dev_ff + 1'b1;
               end
            end
         end
         rsrs_pkg::ST_ERROR: begin
            if (out_free) begin
               o_dev_ff  <= '0;
               o_addr_ff <= '0;
               o_len_ff  <= '0;
               o_row_ff  <= '0;
               o_last_ff <= 1'b1;
               o_err_ff  <= 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, o_row_ff, o_len_ff, o_addr_ff, o_dev_ff};
   assign rsp_tlast  = o_last_ff;
   assign rsp_tuser  = o_err_ff;

endmodule
